// File: hdl/int8_conv5x5_requant_maxpool_unit_macros.svh
// Assertion macros for the conv5x5 requant maxpool unit checkers.
`ifndef INT8_CONV5X5_REQUANT_MAXPOOL_UNIT_MACROS_SVH
`define INT8_CONV5X5_REQUANT_MAXPOOL_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ICRM_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ICRM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

// File: hdl/icrm_pkg.sv
// Shared types and constants of the conv5x5 requant maxpool unit.
package icrm_pkg;

  localparam int KSIZE = 5;
  localparam int NTAPS = KSIZE * KSIZE;
  localparam int NCHAN = 3;
  localparam int ACC_W = 22;
  localparam int PROD_W = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_REQ,
    ST_POOL,
    ST_EMIT
  } state_t;

  typedef logic [7:0] byte_t;

  localparam logic signed [7:0] KERN [NCHAN][NTAPS] = '{
    '{ 8'sd45,  8'sd90,  8'sd68,  8'sd80,  8'sd125,
       8'sd61,  8'sd39,  8'sd102, 8'sd77,  8'sd49,
       8'sd29,  8'sd66, -8'sd6,  -8'sd60, -8'sd61,
       8'sd51, -8'sd9,  -8'sd58, -8'sd32, -8'sd101,
      -8'sd45,  8'sd31,  8'sd7,   8'sd50, -8'sd14 },
    '{ 8'sd65,  8'sd68, -8'sd15,  8'sd26, -8'sd61,
       8'sd66,  8'sd19,  8'sd101, 8'sd84,  8'sd95,
       8'sd76,  8'sd33,  8'sd107, 8'sd118, 8'sd94,
       8'sd4,   8'sd86,  8'sd80,  8'sd79,  8'sd127,
       8'sd28, -8'sd33, -8'sd54,  8'sd41,  8'sd64 },
    '{ 8'sd30,  8'sd88,  8'sd70,  8'sd49, -8'sd49,
       8'sd49,  8'sd51,  8'sd59, -8'sd14, -8'sd113,
       8'sd89,  8'sd71,  8'sd54, -8'sd68, -8'sd89,
       8'sd93,  8'sd34, -8'sd2,  -8'sd49, -8'sd102,
       8'sd71,  8'sd69, -8'sd39, -8'sd82, -8'sd102 }
  };

  localparam logic signed [ACC_W-1:0] BIAS [NCHAN] = '{
    22'sd3563, -22'sd209, -22'sd9502
  };

  localparam logic [10:0] MULT_RESET = 11'd24;

  localparam logic CFG_MULT = 1'b0;
  localparam logic CFG_ZP   = 1'b1;

endpackage

// File: hdl/int8_conv5x5_requant_maxpool_unit.sv
// Top level: streaming 5x5 int8 convolution, requantization and 2x2 max pooling.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  input   | in_valid, in_stall (out), pixel, frame_start      | in
//  output  | out_valid, out_stall (in), pool_row, pool_col,     | out
//          | value_chan0..2, frame_done                        |
//  config  | cfg_we, cfg_index, cfg_data                       | in
//
// A word outside the pooled grid or with no full 5x5 window is taken while the
// sequencer stays idle. A window word goes through accept, 25 line-memory reads
// through the one read port with multiply and accumulate, then requant and pool.
// A word that closes a 2x2 pool adds a hand-off state, held there while out_stall blocks it.
// After a window word is accepted, in_stall stays high until the sequencer is idle again.
// Synchronous reset clears counters, state and config; memories are not cleared.
module int8_conv5x5_requant_maxpool_unit #(
  parameter int IMAGE_WIDTH  = 32,
  parameter int IMAGE_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  pool_row,
  output logic [3:0]  pool_col,
  output logic [7:0]  value_chan0,
  output logic [7:0]  value_chan1,
  output logic [7:0]  value_chan2,
  output logic        frame_done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import icrm_pkg::*;

  localparam int CONV_W = IMAGE_WIDTH - KSIZE + 1;
  localparam int CONV_H = IMAGE_HEIGHT - KSIZE + 1;
  localparam int POOL_W = CONV_W / 2;
  localparam int POOL_H = CONV_H / 2;
  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);
  localparam int LDEPTH = KSIZE * IMAGE_WIDTH;
  localparam int LA = $clog2(LDEPTH);
  localparam int PA = (POOL_W > 1) ? $clog2(POOL_W) : 1;
  localparam int PRW = (POOL_H > 1) ? $clog2(POOL_H) : 1;

  // config
  logic [10:0] mult;
  logic [7:0]  zp;

  // position counters
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [2:0]    row_slot;

  state_t state, state_next;

  // latched position of the word under work
  logic [CW-1:0]  cur_c;
  logic [PA-1:0]  cur_pc;
  logic [PRW-1:0] cur_pr;
  logic           ow_odd, oh_odd;

  // window read sequencer
  logic [4:0] cnt;
  logic [2:0] rd_slot, rd_kw;
  logic       rd_vld, prod_vld;
  logic [4:0] tap;

  // memories
  byte_t          line_mem [LDEPTH];
  logic [LA-1:0]  line_addr;
  byte_t          line_rd;
  logic [23:0]    pair_mem [POOL_W];
  logic [23:0]    pair_rd;

  logic signed [PROD_W-1:0] prod [NCHAN];
  logic signed [ACC_W-1:0]  acc  [NCHAN];
  logic signed [33:0]       scaled [NCHAN];
  byte_t                    hold [NCHAN];
  byte_t                    res  [NCHAN];
  logic                     res_done;

  // pooling combinational values
  byte_t v [NCHAN];
  byte_t pm [NCHAN];
  byte_t fin [NCHAN];

  // accept-cycle decode
  logic          accept;
  logic [CW-1:0] c_in;
  logic [RW-1:0] r_in;
  logic [2:0]    slot_in;
  logic          win;
  logic          load_out;

  assign accept  = in_valid && !in_stall;
  assign c_in    = frame_start ? '0 : col_pos;
  assign r_in    = frame_start ? '0 : row_pos;
  assign slot_in = frame_start ? 3'd0 : row_slot;
  assign win = (int'(r_in) >= KSIZE - 1) && (int'(c_in) >= KSIZE - 1)
            && ((int'(c_in) - (KSIZE - 1)) / 2 < POOL_W)
            && ((int'(r_in) - (KSIZE - 1)) / 2 < POOL_H);

  // line slot of window row kh is (current slot + 1 + kh) mod 5
  assign line_addr = LA'(int'(rd_slot) * IMAGE_WIDTH + int'(cur_c) - (KSIZE - 1) + int'(rd_kw));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && win) state_next = ST_MAC;
      ST_MAC:  if (cnt == 5'(NTAPS + 1)) state_next = ST_REQ;
      ST_REQ:  state_next = ST_POOL;
      ST_POOL: state_next = (ow_odd && oh_odd) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EMIT: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // requant, clamp (ReLU) and pair max
  always_comb begin
    logic signed [19:0] y;
    for (int ch = 0; ch < NCHAN; ch++) begin
      y = 20'(scaled[ch] >>> 15) + $signed({12'd0, zp});
      if (y < 0) v[ch] = 8'd0;
      else if (y > 20'sd255) v[ch] = 8'd255;
      else v[ch] = y[7:0];
      pm[ch] = (hold[ch] > v[ch]) ? hold[ch] : v[ch];
      fin[ch] = (pair_rd[8*ch +: 8] > pm[ch]) ? pair_rd[8*ch +: 8] : pm[ch];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mult      <= MULT_RESET;
      zp        <= 8'd0;
      col_pos   <= '0;
      row_pos   <= '0;
      row_slot  <= 3'd0;
      out_valid <= 1'b0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      prod_vld  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MULT: mult <= cfg_data;
          CFG_ZP:   zp   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (int'(c_in) == IMAGE_WIDTH - 1) begin
          col_pos <= '0;
          if (int'(r_in) == IMAGE_HEIGHT - 1) begin
            row_pos  <= '0;
            row_slot <= 3'd0;
          end else begin
            row_pos  <= r_in + RW'(1);
            row_slot <= (slot_in == 3'd4) ? 3'd0 : slot_in + 3'd1;
          end
        end else begin
          col_pos  <= c_in + CW'(1);
          row_pos  <= r_in;
          row_slot <= slot_in;
        end
      end
      if (state == ST_MAC) begin
        cnt      <= cnt + 5'd1;
        rd_vld   <= cnt < 5'(NTAPS);
        prod_vld <= rd_vld;
      end else begin
        cnt      <= '0;
        rd_vld   <= 1'b0;
        prod_vld <= 1'b0;
      end
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_c  <= c_in;
      cur_pc <= PA'((int'(c_in) - (KSIZE - 1)) / 2);
      cur_pr <= PRW'((int'(r_in) - (KSIZE - 1)) / 2);
      ow_odd <= c_in[0] ^ 1'b0 ^ ((KSIZE - 1) % 2 == 1);
      oh_odd <= r_in[0] ^ ((KSIZE - 1) % 2 == 1);
      rd_slot <= (slot_in == 3'd4) ? 3'd0 : slot_in + 3'd1;
      rd_kw   <= 3'd0;
      for (int ch = 0; ch < NCHAN; ch++) acc[ch] <= BIAS[ch];
    end
    if (state == ST_MAC) begin
      if (cnt < 5'(NTAPS)) begin
        if (rd_kw == 3'(KSIZE - 1)) begin
          rd_kw   <= 3'd0;
          rd_slot <= (rd_slot == 3'd4) ? 3'd0 : rd_slot + 3'd1;
        end else begin
          rd_kw <= rd_kw + 3'd1;
        end
      end
      tap <= cnt;
      if (rd_vld) begin
        for (int ch = 0; ch < NCHAN; ch++)
          prod[ch] <= $signed({1'b0, line_rd}) * KERN[ch][tap];
      end
      if (prod_vld) begin
        for (int ch = 0; ch < NCHAN; ch++)
          acc[ch] <= acc[ch] + ACC_W'(prod[ch]);
      end
    end
    if (state == ST_REQ) begin
      for (int ch = 0; ch < NCHAN; ch++)
        scaled[ch] <= 34'(acc[ch]) * $signed({23'd0, mult});
    end
    if (state == ST_POOL) begin
      if (!ow_odd) begin
        for (int ch = 0; ch < NCHAN; ch++) hold[ch] <= v[ch];
      end else if (!oh_odd) begin
        pair_mem[cur_pc] <= {pm[2], pm[1], pm[0]};
      end else begin
        for (int ch = 0; ch < NCHAN; ch++) res[ch] <= fin[ch];
        res_done <= (int'(cur_pr) == POOL_H - 1) && (int'(cur_pc) == POOL_W - 1);
      end
    end
    if (load_out) begin
      pool_row    <= 4'(cur_pr);
      pool_col    <= 4'(cur_pc);
      value_chan0 <= res[0];
      value_chan1 <= res[1];
      value_chan2 <= res[2];
      frame_done  <= res_done;
    end
  end

  // line memory: pixel written on accept, window read one tap a cycle
  always_ff @(posedge clk) begin
    if (accept) line_mem[LA'(int'(slot_in) * IMAGE_WIDTH + int'(c_in))] <= pixel;
    line_rd <= line_mem[line_addr];
  end

  // pair-max memory read port
  always_ff @(posedge clk) begin
    pair_rd <= pair_mem[cur_pc];
  end

endmodule

// File: hdl/icrm_checker.sv
// Port-level checker for the conv5x5 requant maxpool unit, with its bind.
`include "int8_conv5x5_requant_maxpool_unit_macros.svh"

module icrm_checker #(
  parameter int IMAGE_WIDTH  = 32,
  parameter int IMAGE_HEIGHT = 32
) (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] pool_row,
  input logic [3:0] pool_col,
  input logic       frame_done
);
  localparam int PW = (IMAGE_WIDTH - 4) / 2;
  localparam int PH = (IMAGE_HEIGHT - 4) / 2;
  localparam logic [3:0] LAST_COL = 4'(PW - 1);
  localparam logic [3:0] LAST_ROW = 4'(PH - 1);

  `ICRM_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid, "word dropped under stall")
  `ICRM_ASSERT_IMPL(a_new_word_busy, clk, rst, $rose(out_valid), $past(in_stall), "result not from sequencer")
  `ICRM_ASSERT_IMPL(a_done_col, clk, rst, out_valid && frame_done, pool_col == LAST_COL, "frame_done off last column")
  `ICRM_ASSERT_IMPL(a_done_row, clk, rst, out_valid && frame_done, pool_row == LAST_ROW, "frame_done off last row")
endmodule

bind int8_conv5x5_requant_maxpool_unit icrm_checker #(
  .IMAGE_WIDTH(IMAGE_WIDTH),
  .IMAGE_HEIGHT(IMAGE_HEIGHT)
) u_icrm_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .pool_row(pool_row),
  .pool_col(pool_col),
  .frame_done(frame_done)
);

// File: bench/testbench.sv
// Self-checking bench for the conv5x5 requant maxpool unit: frames in, pooled words checked.
`timescale 1ns / 100ps

module testbench;
  import icrm_pkg::*;

  localparam int IMG_W = 32;
  localparam int IMG_H = 32;
  localparam int POOL_W = (IMG_W - 4) / 2;
  localparam int POOL_H = (IMG_H - 4) / 2;
  // quiet time chosen to cover a window word still at work inside the block
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 200000;

  // pixel pattern kinds for generated frames
  typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_BINARY, PAT_DIM} pat_t;

  // queue entry kinds: a pixel word, a register write, a wait for an empty block
  typedef enum int {K_PIXEL, K_CFG, K_DRAIN} kind_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  pix;
    logic        fs;
    logic        idx;
    logic [10:0] val;
  } item_t;

  typedef struct {
    logic [3:0] prow;
    logic [3:0] pcol;
    logic [7:0] v0;
    logic [7:0] v1;
    logic [7:0] v2;
    logic       done;
  } pool_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel = 8'd0;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  pool_row;
  logic [3:0]  pool_col;
  logic [7:0]  value_chan0;
  logic [7:0]  value_chan1;
  logic [7:0]  value_chan2;
  logic        frame_done;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_MULT;
  logic [10:0] cfg_data = 11'd0;

  // stimulus and scoreboard state
  item_t      items [$];
  pool_word_t exp_q [$];
  int         errors = 0;
  int         rx_count = 0;
  int         cyc = 0;
  int         gap_left = 0;
  int         burst_left = 1;
  int         quiet = 0;
  int         hold_cnt = 0;
  bit         long_done = 1'b0;
  bit         sending_done = 1'b0;

  // behavioral model state
  byte_t m_line [KSIZE][IMG_W];
  byte_t m_pair [NCHAN][POOL_W + 1];
  byte_t m_hold [NCHAN];
  int    m_row, m_col;
  int    m_mult, m_zp;

  always #5 clk = ~clk;

  int8_conv5x5_requant_maxpool_unit #(.IMAGE_WIDTH(IMG_W), .IMAGE_HEIGHT(IMG_H)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall), .pool_row(pool_row), .pool_col(pool_col),
    .value_chan0(value_chan0), .value_chan1(value_chan1), .value_chan2(value_chan2),
    .frame_done(frame_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic byte_t m_requant(longint acc);
    longint y;
    y = (acc * m_mult) >>> 15;
    y = y + m_zp;
    if (y < 0) return 8'd0;
    if (y > 255) return 8'd255;
    return 8'(y);
  endfunction

  function automatic void m_config(logic idx, logic [10:0] val);
    if (idx == CFG_MULT) m_mult = int'(val);
    else m_zp = int'(val[7:0]);
  endfunction

  function automatic bit m_step(logic [7:0] pix, logic fs, output pool_word_t w);
    int     oh, ow, pc, pr;
    longint acc;
    byte_t  v [NCHAN];
    byte_t  vals [NCHAN];
    byte_t  pm;
    bit     produced;
    produced = 1'b0;
    w = '{default: '0};
    if (fs) begin
      m_row = 0;
      m_col = 0;
    end
    m_line[m_row % KSIZE][m_col] = pix;
    if (m_row >= KSIZE - 1 && m_col >= KSIZE - 1) begin
      oh = m_row - (KSIZE - 1);
      ow = m_col - (KSIZE - 1);
      for (int ch = 0; ch < NCHAN; ch++) begin
        acc = BIAS[ch];
        for (int kh = 0; kh < KSIZE; kh++) begin
          for (int kw = 0; kw < KSIZE; kw++)
            acc += longint'(m_line[(oh + kh) % KSIZE][ow + kw]) * KERN[ch][kh * KSIZE + kw];
        end
        v[ch] = m_requant(acc);
      end
      pc = ow / 2;
      pr = oh / 2;
      if (pc < POOL_W && pr < POOL_H) begin
        if (ow % 2 == 0) begin
          for (int ch = 0; ch < NCHAN; ch++) m_hold[ch] = v[ch];
        end else begin
          for (int ch = 0; ch < NCHAN; ch++) begin
            pm = (m_hold[ch] > v[ch]) ? m_hold[ch] : v[ch];
            if (oh % 2 == 0) m_pair[ch][pc] = pm;
            else vals[ch] = (m_pair[ch][pc] > pm) ? m_pair[ch][pc] : pm;
          end
          if (oh % 2 == 1) begin
            w.prow = 4'(pr);
            w.pcol = 4'(pc);
            w.v0 = vals[0];
            w.v1 = vals[1];
            w.v2 = vals[2];
            w.done = (pr == POOL_H - 1) && (pc == POOL_W - 1);
            produced = 1'b1;
          end
        end
      end
    end
    m_col++;
    if (m_col >= IMG_W) begin
      m_col = 0;
      m_row++;
      if (m_row >= IMG_H) m_row = 0;
    end
    return produced;
  endfunction

  function automatic logic [7:0] gen_pix(pat_t p);
    case (p)
      PAT_WHITE:  return 8'hFF;
      PAT_BLACK:  return 8'h00;
      PAT_BINARY: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      PAT_DIM:    return 8'($urandom_range(0, 15));
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic void add_pixels(int count, bit fs_first);
    item_t it;
    pat_t  pat;
    pat = PAT_RANDOM;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) pat = pat_t'($urandom_range(0, 4));
      it = '{kind: K_PIXEL, pix: gen_pix(pat), fs: (fs_first && n == 0), idx: 1'b0,
             val: 11'd0};
      items.push_back(it);
    end
  endfunction

  function automatic void add_cfg(logic idx, logic [10:0] val);
    item_t it;
    it = '{kind: K_CFG, pix: 8'd0, fs: 1'b0, idx: idx, val: val};
    items.push_back(it);
  endfunction

  function automatic void add_drain();
    item_t it;
    it = '{kind: K_DRAIN, pix: 8'd0, fs: 1'b0, idx: 1'b0, val: 11'd0};
    items.push_back(it);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("cycle limit reached, %0d words still expected", exp_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver: bursts of pixel words, register writes only once the block is empty
  always @(posedge clk) begin
    logic        nv, nfs, nwe, nidx;
    logic [7:0]  npix;
    logic [10:0] nval;
    int          ngap, nburst, nquiet;
    bit          ndone;
    nv = in_valid;
    npix = pixel;
    nfs = frame_start;
    nwe = 1'b0;
    nidx = cfg_index;
    nval = cfg_data;
    ngap = gap_left;
    nburst = burst_left;
    ndone = sending_done;
    nquiet = (in_valid && !in_stall) ? 0 : quiet + 1;
    if (rst) begin
      nv = 1'b0;
      ngap = 0;
      nburst = 1;
      nquiet = 0;
      ndone = 1'b0;
    end else if (!(in_valid && in_stall)) begin
      nv = 1'b0;
      if (items.size() == 0) begin
        ndone = 1'b1;
      end else if (ngap > 0) begin
        ngap--;
      end else begin
        case (items[0].kind)
          K_PIXEL: begin
            npix = items[0].pix;
            nfs = items[0].fs;
            nv = 1'b1;
            void'(items.pop_front());
            nburst--;
            if (nburst <= 0) begin
              nburst = $urandom_range(1, 40);
              ngap = $urandom_range(0, 12);
            end
          end
          K_DRAIN: begin
            if (nquiet >= DRAIN_CYCLES && !out_valid) void'(items.pop_front());
          end
          K_CFG: begin
            nwe = 1'b1;
            nidx = items[0].idx;
            nval = items[0].val;
            void'(items.pop_front());
          end
          default: ;
        endcase
      end
    end
    in_valid <= nv;
    pixel <= npix;
    frame_start <= nfs;
    cfg_we <= nwe;
    cfg_index <= nidx;
    cfg_data <= nval;
    gap_left <= ngap;
    burst_left <= nburst;
    quiet <= nquiet;
    sending_done <= ndone;
  end

  // receiver: one long hold early on, then a stall pattern of its own
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      long_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else if (!long_done && rx_count >= 2) begin
      out_stall <= 1'b1;
      hold_cnt <= LONG_HOLD;
      long_done <= 1'b1;
    end else begin
      out_stall <= (cyc % 5 == 2) || ($urandom_range(0, 3) == 0);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    pool_word_t w;
    pool_word_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        rx_count <= rx_count + 1;
        if (exp_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected word: row %0d col %0d values %0d %0d %0d done %0d",
                     pool_row, pool_col, value_chan0, value_chan1, value_chan2, frame_done);
          errors++;
        end else begin
          e = exp_q.pop_front();
          if (e.prow !== pool_row || e.pcol !== pool_col || e.v0 !== value_chan0 ||
              e.v1 !== value_chan1 || e.v2 !== value_chan2 || e.done !== frame_done) begin
            if (errors < 10)
              $display("mismatch: expected row %0d col %0d values %0d %0d %0d done %0d, got row %0d col %0d values %0d %0d %0d done %0d",
                       e.prow, e.pcol, e.v0, e.v1, e.v2, e.done,
                       pool_row, pool_col, value_chan0, value_chan1, value_chan2,
                       frame_done);
            errors++;
          end
        end
      end
      if (cfg_we) m_config(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        if (m_step(pixel, frame_start, w)) exp_q.push_back(w);
      end
    end
  end

  initial begin
    m_mult = 24;
    m_zp = 0;
    m_row = 0;
    m_col = 0;
    foreach (m_line[i, j]) m_line[i][j] = 8'd0;
    foreach (m_pair[i, j]) m_pair[i][j] = 8'd0;
    foreach (m_hold[i]) m_hold[i] = 8'd0;

    // first frame at reset scaling
    add_pixels(200, 1'b1);
    // strong scaling with a masked zero point, then a restart mid-image
    add_drain();
    add_cfg(CFG_MULT, 11'd700);
    add_cfg(CFG_ZP, 11'h50C);
    add_pixels(300, 1'b1);
    // weak scaling around a high zero point, frame goes on
    add_drain();
    add_cfg(CFG_MULT, 11'd3);
    add_cfg(CFG_ZP, 11'd200);
    add_pixels(300, 1'b0);
    add_drain();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (sending_done);
    repeat (5) @(posedge clk);
    if (errors == 0 && exp_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: bench/testbench_fixed.sv
// (unused)

// File: sim.f
+incdir+hdl
hdl/icrm_pkg.sv
hdl/int8_conv5x5_requant_maxpool_unit.sv
hdl/icrm_checker.sv
bench/testbench.sv
bench/testbench_fixed.sv
